[sv/sds_pkg.sv]
// Shared double stack: package with defaults, request/status codes and the
// controller/datapath command and status structs. No dependencies.
package sds_pkg;

  localparam int unsigned SDS_DEPTH     = 64;
  localparam int unsigned SDS_WORD_BITS = 32;
  localparam int unsigned IO_BITS       = 32;

  typedef enum logic [1:0] {
    REQ_PUSH_LO = 2'd0,
    REQ_PUSH_HI = 2'd1,
    REQ_POP_LO  = 2'd2,
    REQ_POP_HI  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  // controller -> datapath
  typedef struct packed {
    logic take;   // an item is accepted this cycle
    logic load;   // RAM read data is valid, capture it
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_ok; // item on the input would be a successful pop
  } dp_sts_t;

endpackage

[sv/shared_double_stack_top.sv]
// Shared double stack top level: joins controller and datapath.
// Depends on sds_pkg, sds_ctrl, sds_dp (and sds_ram below it).
//
//   channel | dir | tdata            | tuser
//   in_     | in  | push_value[31:0] | req_type[1:0]
//   out_    | out | pop_value[31:0]  | status[1:0]
//
// One item at a time. A push or a refused request shows its result in the cycle
// after it is taken; a successful pop first passes through S_LOAD for the RAM's
// registered read. The result is held for as long as out_tready is low.
// in_tready is low from acceptance until the result has been taken.
// Synchronous reset empties both stacks; RAM contents are not cleared.
module shared_double_stack_top
  import sds_pkg::*;
#(
  parameter int unsigned DEPTH     = SDS_DEPTH,
  parameter int unsigned WORD_BITS = SDS_WORD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] pop_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sds_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (in_tuser),
    .push_value (in_tdata),
    .pop_value  (out_tdata),
    .status     (out_tuser)
  );

endmodule

[sv/sds_ram.sv]
// Generic single-port RAM, one read or write per cycle, registered read data.
// No dependencies.
module sds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

endmodule

[sv/sds_ctrl.sv]
// Shared double stack controller: handshake state machine.
// Depends on sds_pkg.
module sds_ctrl
  import sds_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOAD = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign cmd.take   = in_tready & in_tvalid;
  assign cmd.load   = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.pop_ok ? S_LOAD : S_OUT;
        end
      end
      S_LOAD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/sds_dp.sv]
// Shared double stack datapath: stack counts, address logic, shared RAM and
// result register. Depends on sds_pkg and sds_ram.
module sds_dp
  import sds_pkg::*;
#(
  parameter int unsigned DEPTH     = SDS_DEPTH,
  parameter int unsigned WORD_BITS = SDS_WORD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [1:0]         req_type,
  input  logic [IO_BITS-1:0] push_value,
  output logic [IO_BITS-1:0] pop_value,
  output logic [1:0]         status
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [CW-1:0] lo_cnt_r, lo_cnt_nxt;
  logic [CW-1:0] hi_cnt_r, hi_cnt_nxt;
  logic [IO_BITS-1:0] pop_value_r, pop_value_nxt;
  stat_t status_r, status_nxt;

  logic [CW:0]          used;
  logic                 full;
  logic                 ram_we;
  logic [CW-1:0]        addr_c;
  logic [WORD_BITS-1:0] wword;
  logic [WORD_BITS-1:0] rword;
  logic [IO_BITS-1:0]   rword_io;
  req_t                 req;

  assign req  = req_t'(req_type);
  assign used = {1'b0, lo_cnt_r} + {1'b0, hi_cnt_r};
  assign full = (used >= {1'b0, DEPTH_C});

  // narrow: stored word is the low WORD_BITS of the input, result zero-extended; wide: the reverse
  if (WORD_BITS <= IO_BITS) begin : g_narrow
    assign wword    = push_value[WORD_BITS-1:0];
    assign rword_io = IO_BITS'(rword);
  end else begin : g_wide
    assign wword    = WORD_BITS'(push_value);
    assign rword_io = rword[IO_BITS-1:0];
  end

  always_comb begin
    lo_cnt_nxt    = lo_cnt_r;
    hi_cnt_nxt    = hi_cnt_r;
    status_nxt    = STAT_DONE;
    sts.pop_ok    = 1'b0;
    ram_we        = 1'b0;
    addr_c        = lo_cnt_r;
    unique case (req)
      REQ_PUSH_LO: begin
        addr_c = lo_cnt_r;
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          ram_we     = 1'b1;
          lo_cnt_nxt = lo_cnt_r + ONE_C;
        end
      end
      REQ_PUSH_HI: begin
        addr_c = DEPTH_C - hi_cnt_r - ONE_C;
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          ram_we     = 1'b1;
          hi_cnt_nxt = hi_cnt_r + ONE_C;
        end
      end
      REQ_POP_LO: begin
        addr_c = lo_cnt_r - ONE_C;
        if (lo_cnt_r == '0) begin
          status_nxt = STAT_EMPTY;
        end else begin
          sts.pop_ok = 1'b1;
          lo_cnt_nxt = lo_cnt_r - ONE_C;
        end
      end
      REQ_POP_HI: begin
        addr_c = DEPTH_C - hi_cnt_r;
        if (hi_cnt_r == '0) begin
          status_nxt = STAT_EMPTY;
        end else begin
          sts.pop_ok = 1'b1;
          hi_cnt_nxt = hi_cnt_r - ONE_C;
        end
      end
      default: begin
        status_nxt = STAT_DONE;
      end
    endcase
  end

  assign pop_value_nxt = cmd.load ? rword_io : '0;

  sds_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we & cmd.take),
    .addr    (addr_c[AW-1:0]),
    .wdata   (wword),
    .rdata_r (rword)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_cnt_r <= '0;
      hi_cnt_r <= '0;
    end else if (cmd.take) begin
      lo_cnt_r <= lo_cnt_nxt;
      hi_cnt_r <= hi_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      status_r <= status_nxt;
    end
    if (cmd.take || cmd.load) begin
      pop_value_r <= pop_value_nxt;
    end
  end

  assign pop_value = pop_value_r;
  assign status    = status_r;

endmodule
